// ----- rtl/core/iprw_pkg.sv -----
// Shared types, constants and checksum helpers for the address rewrite block.
// Used by iprw_cfg, iprw_calc and ip_address_rewrite_checksum_update.
`timescale 1ns / 1ps

package iprw_pkg;

    // Ether types and L4 protocol numbers that the block acts on.
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IPV6_MODE   = 3'd0,
        CFG_MATCH_HIGH  = 3'd1,
        CFG_MATCH_LOW   = 3'd2,
        CFG_NEW_HIGH    = 3'd3,
        CFG_NEW_LOW     = 3'd4
    } t_cfg_idx;

    localparam int ADDR_W = 64;
    localparam int WORD_W = 16;

    // Raw sum of up to sixteen 16-bit words fits in 20 bits.
    localparam int DELTA_W = 20;
    // Complemented checksum plus twice the raw delta fits in 22 bits.
    localparam int TOTAL_W = DELTA_W + 2;

    // Configuration seen by the datapath, with the precomputed address delta.
    typedef struct packed {
        logic               ipv6_mode;
        logic [ADDR_W-1:0]  match_high;
        logic [ADDR_W-1:0]  match_low;
        logic [ADDR_W-1:0]  new_high;
        logic [ADDR_W-1:0]  new_low;
        logic [DELTA_W-1:0] delta;
    } t_cfg;

    // End-around carry fold of a raw ones' complement sum down to 16 bits.
    // Two passes suffice for a 22-bit sum; a nonzero sum stays nonzero.
    function automatic logic [WORD_W-1:0] fold_sum(input logic [TOTAL_W-1:0] total);
        logic [WORD_W:0] pass1;
        logic [WORD_W:0] pass2;
        begin
            pass1 = {1'b0, total[WORD_W-1:0]}
                  + {{(WORD_W+1-(TOTAL_W-WORD_W)){1'b0}}, total[TOTAL_W-1:WORD_W]};
            pass2 = {1'b0, pass1[WORD_W-1:0]} + {{WORD_W{1'b0}}, pass1[WORD_W]};
            fold_sum = pass2[WORD_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/ip_address_rewrite_checksum_update.sv -----
// Top level of the address rewrite block: input register, rewrite logic and
// result register. Depends on iprw_pkg, iprw_cfg and iprw_calc.
`timescale 1ns / 1ps

// One header beat enters per cycle while the input is not stalled; its result
// passes through the input register and then the result register, with the
// match, rewrite and checksum update between them. Throughput is one beat per
// cycle as long as the output side does not stall; a stall holds the result
// register and, once the input register is also full, pushes back on the input.
// Configuration writes take effect for beats accepted on the following cycle.
module ip_address_rewrite_checksum_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [iprw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [iprw_pkg::ADDR_W-1:0]         i_cfg_wdata,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [15:0]                         i_ether_type,
    input  logic [7:0]                          i_l4_protocol,
    input  logic [iprw_pkg::ADDR_W-1:0]         i_src_high,
    input  logic [iprw_pkg::ADDR_W-1:0]         i_src_low,
    input  logic [iprw_pkg::ADDR_W-1:0]         i_dst_high,
    input  logic [iprw_pkg::ADDR_W-1:0]         i_dst_low,
    input  logic [15:0]                         i_ip_header_checksum,
    input  logic [15:0]                         i_l4_checksum,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [iprw_pkg::ADDR_W-1:0]         o_out_src_high,
    output logic [iprw_pkg::ADDR_W-1:0]         o_out_src_low,
    output logic [iprw_pkg::ADDR_W-1:0]         o_out_dst_high,
    output logic [iprw_pkg::ADDR_W-1:0]         o_out_dst_low,
    output logic [15:0]                         o_out_ip_checksum,
    output logic [15:0]                         o_out_l4_checksum,
    output logic                                o_src_rewritten,
    output logic                                o_dst_rewritten
);

    iprw_pkg::t_cfg                    cfg;

    logic                              out_load;
    logic                              in_load;

    // Input register.
    logic                              r_in_valid;
    logic [15:0]                       r_ether_type;
    logic [7:0]                        r_l4_protocol;
    logic [iprw_pkg::ADDR_W-1:0]       r_src_high;
    logic [iprw_pkg::ADDR_W-1:0]       r_src_low;
    logic [iprw_pkg::ADDR_W-1:0]       r_dst_high;
    logic [iprw_pkg::ADDR_W-1:0]       r_dst_low;
    logic [15:0]                       r_ip_cs;
    logic [15:0]                       r_l4_cs;

    // Next values of the result register.
    logic [iprw_pkg::ADDR_W-1:0]       n_src_high;
    logic [iprw_pkg::ADDR_W-1:0]       n_src_low;
    logic [iprw_pkg::ADDR_W-1:0]       n_dst_high;
    logic [iprw_pkg::ADDR_W-1:0]       n_dst_low;
    logic [15:0]                       n_ip_cs;
    logic [15:0]                       n_l4_cs;
    logic                              n_src_rw;
    logic                              n_dst_rw;

    // Result register.
    logic                              r_out_valid;
    logic [iprw_pkg::ADDR_W-1:0]       r_src_high_q;
    logic [iprw_pkg::ADDR_W-1:0]       r_src_low_q;
    logic [iprw_pkg::ADDR_W-1:0]       r_dst_high_q;
    logic [iprw_pkg::ADDR_W-1:0]       r_dst_low_q;
    logic [15:0]                       r_ip_cs_q;
    logic [15:0]                       r_l4_cs_q;
    logic                              r_src_rw_q;
    logic                              r_dst_rw_q;

    iprw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Pipeline flow: a stage loads when it is empty or its beat moves on.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    // Input register: valid bit and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_ether_type  <= i_ether_type;
            r_l4_protocol <= i_l4_protocol;
            r_src_high    <= i_src_high;
            r_src_low     <= i_src_low;
            r_dst_high    <= i_dst_high;
            r_dst_low     <= i_dst_low;
            r_ip_cs       <= i_ip_header_checksum;
            r_l4_cs       <= i_l4_checksum;
        end
    end

    iprw_calc u_calc (
        .i_cfg                (cfg),
        .i_ether_type         (r_ether_type),
        .i_l4_protocol        (r_l4_protocol),
        .i_src_high           (r_src_high),
        .i_src_low            (r_src_low),
        .i_dst_high           (r_dst_high),
        .i_dst_low            (r_dst_low),
        .i_ip_header_checksum (r_ip_cs),
        .i_l4_checksum        (r_l4_cs),
        .o_out_src_high       (n_src_high),
        .o_out_src_low        (n_src_low),
        .o_out_dst_high       (n_dst_high),
        .o_out_dst_low        (n_dst_low),
        .o_out_ip_checksum    (n_ip_cs),
        .o_out_l4_checksum    (n_l4_cs),
        .o_src_rewritten      (n_src_rw),
        .o_dst_rewritten      (n_dst_rw)
    );

    // Result register: valid bit and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_src_high_q <= n_src_high;
            r_src_low_q  <= n_src_low;
            r_dst_high_q <= n_dst_high;
            r_dst_low_q  <= n_dst_low;
            r_ip_cs_q    <= n_ip_cs;
            r_l4_cs_q    <= n_l4_cs;
            r_src_rw_q   <= n_src_rw;
            r_dst_rw_q   <= n_dst_rw;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_src_high    = r_src_high_q;
    assign o_out_src_low     = r_src_low_q;
    assign o_out_dst_high    = r_dst_high_q;
    assign o_out_dst_low     = r_dst_low_q;
    assign o_out_ip_checksum = r_ip_cs_q;
    assign o_out_l4_checksum = r_l4_cs_q;
    assign o_src_rewritten   = r_src_rw_q;
    assign o_dst_rewritten   = r_dst_rw_q;

endmodule

// ----- rtl/core/iprw_cfg.sv -----
// Configuration registers of the address rewrite block, plus the registered
// per-address checksum delta. Depends on iprw_pkg.
`timescale 1ns / 1ps

module iprw_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [iprw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [iprw_pkg::ADDR_W-1:0]          i_cfg_wdata,
    output iprw_pkg::t_cfg                       o_cfg
);

    logic                              r_ipv6_mode;
    logic [iprw_pkg::ADDR_W-1:0]       r_match_high;
    logic [iprw_pkg::ADDR_W-1:0]       r_match_low;
    logic [iprw_pkg::ADDR_W-1:0]       r_new_high;
    logic [iprw_pkg::ADDR_W-1:0]       r_new_low;
    logic [iprw_pkg::DELTA_W-1:0]      r_delta;
    logic [iprw_pkg::DELTA_W-1:0]      n_delta;

    // Word pair sums: inverted words of the match address, plain words of the new one.
    logic [16:0]                       ml_lo;
    logic [16:0]                       ml_hi;
    logic [16:0]                       mh_lo;
    logic [16:0]                       mh_hi;
    logic [16:0]                       nl_lo;
    logic [16:0]                       nl_hi;
    logic [16:0]                       nh_lo;
    logic [16:0]                       nh_hi;
    logic [17:0]                       v4_sum;
    logic [17:0]                       low_hi_sum;
    logic [17:0]                       high_lo_sum;
    logic [17:0]                       high_hi_sum;
    logic [18:0]                       low_sum;
    logic [18:0]                       high_sum;

    // Register writes; all registers reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipv6_mode  <= 1'b0;
            r_match_high <= '0;
            r_match_low  <= '0;
            r_new_high   <= '0;
            r_new_low    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iprw_pkg::CFG_IPV6_MODE:  r_ipv6_mode  <= i_cfg_wdata[0];
                iprw_pkg::CFG_MATCH_HIGH: r_match_high <= i_cfg_wdata;
                iprw_pkg::CFG_MATCH_LOW:  r_match_low  <= i_cfg_wdata;
                iprw_pkg::CFG_NEW_HIGH:   r_new_high   <= i_cfg_wdata;
                iprw_pkg::CFG_NEW_LOW:    r_new_low    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Raw sum of (~old word + new word) over the words of one address, built
    // as a shallow adder tree. IPv4 covers the two words of bits 31..0; IPv6
    // covers all eight words.
    assign ml_lo = {1'b0, ~r_match_low[15:0]}   + {1'b0, ~r_match_low[31:16]};
    assign ml_hi = {1'b0, ~r_match_low[47:32]}  + {1'b0, ~r_match_low[63:48]};
    assign mh_lo = {1'b0, ~r_match_high[15:0]}  + {1'b0, ~r_match_high[31:16]};
    assign mh_hi = {1'b0, ~r_match_high[47:32]} + {1'b0, ~r_match_high[63:48]};
    assign nl_lo = {1'b0, r_new_low[15:0]}      + {1'b0, r_new_low[31:16]};
    assign nl_hi = {1'b0, r_new_low[47:32]}     + {1'b0, r_new_low[63:48]};
    assign nh_lo = {1'b0, r_new_high[15:0]}     + {1'b0, r_new_high[31:16]};
    assign nh_hi = {1'b0, r_new_high[47:32]}    + {1'b0, r_new_high[63:48]};

    assign v4_sum      = {1'b0, ml_lo} + {1'b0, nl_lo};
    assign low_hi_sum  = {1'b0, ml_hi} + {1'b0, nl_hi};
    assign high_lo_sum = {1'b0, mh_lo} + {1'b0, nh_lo};
    assign high_hi_sum = {1'b0, mh_hi} + {1'b0, nh_hi};
    assign low_sum     = {1'b0, v4_sum} + {1'b0, low_hi_sum};
    assign high_sum    = {1'b0, high_lo_sum} + {1'b0, high_hi_sum};

    always_comb begin
        if (r_ipv6_mode) begin
            n_delta = {1'b0, low_sum} + {1'b0, high_sum};
        end else begin
            n_delta = {2'b0, v4_sum};
        end
    end

    // The delta is registered from the configuration registers and follows them
    // in the cycle after they change.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
        end else begin
            r_delta <= n_delta;
        end
    end

    assign o_cfg = '{
        ipv6_mode:  r_ipv6_mode,
        match_high: r_match_high,
        match_low:  r_match_low,
        new_high:   r_new_high,
        new_low:    r_new_low,
        delta:      r_delta
    };

endmodule

// ----- rtl/core/iprw_calc.sv -----
// Address match, rewrite and incremental checksum update for one header beat.
// Purely combinational; depends on iprw_pkg.
`timescale 1ns / 1ps

module iprw_calc (
    input  iprw_pkg::t_cfg                 i_cfg,
    input  logic [15:0]                    i_ether_type,
    input  logic [7:0]                     i_l4_protocol,
    input  logic [iprw_pkg::ADDR_W-1:0]    i_src_high,
    input  logic [iprw_pkg::ADDR_W-1:0]    i_src_low,
    input  logic [iprw_pkg::ADDR_W-1:0]    i_dst_high,
    input  logic [iprw_pkg::ADDR_W-1:0]    i_dst_low,
    input  logic [15:0]                    i_ip_header_checksum,
    input  logic [15:0]                    i_l4_checksum,
    output logic [iprw_pkg::ADDR_W-1:0]    o_out_src_high,
    output logic [iprw_pkg::ADDR_W-1:0]    o_out_src_low,
    output logic [iprw_pkg::ADDR_W-1:0]    o_out_dst_high,
    output logic [iprw_pkg::ADDR_W-1:0]    o_out_dst_low,
    output logic [15:0]                    o_out_ip_checksum,
    output logic [15:0]                    o_out_l4_checksum,
    output logic                           o_src_rewritten,
    output logic                           o_dst_rewritten
);

    logic                              v4_pkt;
    logic                              v6_pkt;
    logic                              is_l4;
    logic                              src_hit;
    logic                              dst_hit;
    logic [1:0]                        hits;
    logic [iprw_pkg::TOTAL_W-1:0]      delta_sum;
    logic [iprw_pkg::TOTAL_W-1:0]      ip_total;
    logic [iprw_pkg::TOTAL_W-1:0]      l4_total;
    logic [iprw_pkg::ADDR_W-1:0]       v4_new_low;

    // Packet class for the configured mode.
    assign v4_pkt = !i_cfg.ipv6_mode && (i_ether_type == iprw_pkg::ETH_IPV4);
    assign v6_pkt = i_cfg.ipv6_mode && (i_ether_type == iprw_pkg::ETH_IPV6);
    assign is_l4  = (i_l4_protocol == iprw_pkg::PROTO_TCP)
                 || (i_l4_protocol == iprw_pkg::PROTO_UDP);

    // Address match: IPv4 compares bits 31..0 only, IPv6 all 128 bits.
    always_comb begin
        src_hit = (v4_pkt && (i_src_low[31:0] == i_cfg.match_low[31:0]))
               || (v6_pkt && (i_src_high == i_cfg.match_high)
                          && (i_src_low == i_cfg.match_low));
        dst_hit = (v4_pkt && (i_dst_low[31:0] == i_cfg.match_low[31:0]))
               || (v6_pkt && (i_dst_high == i_cfg.match_high)
                          && (i_dst_low == i_cfg.match_low));
    end

    assign v4_new_low = {32'b0, i_cfg.new_low[31:0]};

    // Rewritten addresses; in IPv4 mode the high word passes untouched.
    always_comb begin
        o_out_src_high = i_src_high;
        o_out_src_low  = i_src_low;
        o_out_dst_high = i_dst_high;
        o_out_dst_low  = i_dst_low;
        if (src_hit) begin
            if (v6_pkt) begin
                o_out_src_high = i_cfg.new_high;
                o_out_src_low  = i_cfg.new_low;
            end else begin
                o_out_src_low  = v4_new_low;
            end
        end
        if (dst_hit) begin
            if (v6_pkt) begin
                o_out_dst_high = i_cfg.new_high;
                o_out_dst_low  = i_cfg.new_low;
            end else begin
                o_out_dst_low  = v4_new_low;
            end
        end
    end

    // Each replaced address adds the delta once; chained RFC 1624 updates
    // collapse into one ones' complement sum followed by a fold.
    assign hits = {1'b0, src_hit} + {1'b0, dst_hit};

    always_comb begin
        case (hits)
            2'd1:    delta_sum = {2'b0, i_cfg.delta};
            2'd2:    delta_sum = {1'b0, i_cfg.delta, 1'b0};
            default: delta_sum = '0;
        endcase
        ip_total = {6'b0, ~i_ip_header_checksum} + (v4_pkt ? delta_sum : '0);
        l4_total = {6'b0, ~i_l4_checksum} + (is_l4 ? delta_sum : '0);
    end

    assign o_out_ip_checksum = ~iprw_pkg::fold_sum(ip_total);
    assign o_out_l4_checksum = ~iprw_pkg::fold_sum(l4_total);
    assign o_src_rewritten   = src_hit;
    assign o_dst_rewritten   = dst_hit;

endmodule
